FILE: rtl/hcbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_pkg: shared types and constants
// Phase codes, result kinds, status codes and character helpers for the
// chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

	// Most hex digits allowed in one chunk-size line
	localparam int MAX_SIZE_DIGITS = 8;
	localparam int DCNT_W          = $clog2(MAX_SIZE_DIGITS + 1);

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_SIZE    = 3'd1,
		PH_DATA    = 3'd2,
		PH_TRAILER = 3'd3,
		PH_DONE    = 3'd4,
		PH_PASS    = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_BODY   = 2'd1,
		KIND_REPORT = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TRUNC    = 2'd1,
		ST_TOO_LONG = 2'd2
	} status_t;

	// Results caused by one accepted word
	typedef struct packed {
		logic          byte_v;
		logic [7:0]    byte_val;
		kind_t         byte_kind;
		logic          rep_v;
		status_t       rep_status;
		logic [31:0]   rep_length;
	} push_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic hex_t hex_decode(logic [7:0] b);
		hex_t r;
		r.ok  = 1'b1;
		r.val = 4'd0;
		case (b) inside
			[8'h30:8'h39]: r.val = b[3:0];
			[8'h61:8'h66],
			[8'h41:8'h46]: r.val = 4'(b[3:0] + 4'd9);
			default:       r.ok = 1'b0;
		endcase
		return r;
	endfunction

	// Letters of "chunked"
	function automatic logic [7:0] kw_char(logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = 8'h63; // c
			3'd1:    c = 8'h68; // h
			3'd2:    c = 8'h75; // u
			3'd3:    c = 8'h6E; // n
			3'd4:    c = 8'h6B; // k
			3'd5:    c = 8'h65; // e
			3'd6:    c = 8'h64; // d
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/hcbd_resp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_resp_if: raw response channel
// One response byte per word, with a final-byte marker.
// ----------------------------------------------------------------------------
interface hcbd_resp_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_response;

	modport source(output valid, data_byte, end_of_response, input ready);
	modport sink(input valid, data_byte, end_of_response, output ready);
endinterface

FILE: rtl/hcbd_body_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_body_if: decoded output channel
// Header bytes, body bytes and end reports.
// ----------------------------------------------------------------------------
interface hcbd_body_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic [1:0]  item_kind;
	logic [1:0]  status;
	logic [31:0] total_length;
	logic        last_result;

	modport source(output valid, out_byte, item_kind, status, total_length, last_result,
		input ready);
	modport sink(input valid, out_byte, item_kind, status, total_length, last_result,
		output ready);
endinterface

FILE: rtl/http_chunked_body_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder: HTTP/1.1 chunked transfer decoder
// Passes header bytes, decodes a chunked body or passes a plain one through,
// and closes each response with an end report of status and total length.
// ----------------------------------------------------------------------------
// Output: a result is registered and appears on body in the next cycle.
// Throughput: one byte per cycle while body is ready and each byte yields at
//   most one result; the final byte of a response can yield a byte and an
//   end report, which leave in turn, so resp waits for the byte to go out.
// Reset: arst_n clears parser state and the result register; the block then
//   scans for a new header. State also returns to reset after each end report.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder import hcbd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	hcbd_resp_if.sink   resp,
	hcbd_body_if.source body
);

	logic  accept;
	push_t push;

	// a word is taken only when the result register can hold what it causes
	assign accept = resp.valid && resp.ready;

	// header scan, keyword match, size-line parsing, length count
	hcbd_parser u_parser (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.data_byte       (resp.data_byte),
		.end_of_response (resp.end_of_response),
		.push            (push)
	);

	// byte slot plus report slot; ready frees up as the slots drain
	hcbd_out_buf u_out_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.push   (push),
		.ready  (resp.ready),
		.body   (body)
	);

	// a final byte always leaves a pending end report behind
	a_report_pending: assert property (@(posedge clk) disable iff (!arst_n)
		accept && resp.end_of_response |=> body.valid)
		else $error("end report missing after final byte");

	// only the end report is marked last
	a_last_is_report: assert property (@(posedge clk) disable iff (!arst_n)
		body.valid && body.last_result |-> body.item_kind == KIND_REPORT)
		else $error("last_result on a byte word");

	// byte words carry no status or length
	a_byte_clean: assert property (@(posedge clk) disable iff (!arst_n)
		body.valid && body.item_kind != KIND_REPORT |->
		body.status == ST_OK && body.total_length == 32'd0)
		else $error("byte word carries report fields");

	// an end report always carries a zero byte
	a_report_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		body.valid && body.item_kind == KIND_REPORT |-> body.out_byte == 8'd0)
		else $error("end report with nonzero byte");

endmodule

FILE: rtl/hcbd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_parser: response parser state
// Header scan, keyword match, chunk-size parsing and length count; updates
// on each accepted word and reports the results that word causes.
// ----------------------------------------------------------------------------
module hcbd_parser import hcbd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       end_of_response,
	output push_t      push
);

	phase_t              phase_q,  phase_d;
	logic [1:0]          blank_q,  blank_d;
	logic [2:0]          kw_q,     kw_d;
	logic                seen_q,   seen_d;
	logic [31:0]         acc_q,    acc_d;
	logic [DCNT_W-1:0]   dcnt_q,   dcnt_d;
	logic                closed_q, closed_d;
	logic                cr_q,     cr_d;
	logic [31:0]         remain_q, remain_d;
	logic [1:0]          tskip_q,  tskip_d;
	logic [31:0]         len_q,    len_d;
	status_t             err_q,    err_d;

	hex_t       hx;
	logic       emit;
	logic [31:0] len_inc;
	status_t    st;

	assign hx      = hex_decode(data_byte);
	assign emit    = (phase_q == PH_HEADER) || (phase_q == PH_DATA) || (phase_q == PH_PASS);
	assign len_inc = (len_q != '1) ? len_q + 32'd1 : len_q;

	always_comb begin
		phase_d  = phase_q;
		blank_d  = blank_q;
		kw_d     = kw_q;
		seen_d   = seen_q;
		acc_d    = acc_q;
		dcnt_d   = dcnt_q;
		closed_d = closed_q;
		cr_d     = cr_q;
		remain_d = remain_q;
		tskip_d  = tskip_q;
		err_d    = err_q;
		len_d    = emit ? len_inc : len_q;
		st       = ST_OK;

		case (phase_q)
			PH_HEADER: begin
				if (data_byte == kw_char(kw_q)) begin
					if (kw_q == 3'd6) begin
						seen_d = 1'b1;
						kw_d   = 3'd0;
					end else begin
						kw_d = kw_q + 3'd1;
					end
				end else begin
					kw_d = (data_byte == kw_char(3'd0)) ? 3'd1 : 3'd0;
				end
				if (data_byte == CH_LF && blank_q == 2'd3) begin
					blank_d = 2'd0;
					if (seen_d) begin
						acc_d    = '0;
						dcnt_d   = '0;
						closed_d = 1'b0;
						cr_d     = 1'b0;
						phase_d  = PH_SIZE;
					end else begin
						phase_d = PH_PASS;
					end
				end else if (data_byte == CH_CR) begin
					blank_d = (blank_q == 2'd2) ? 2'd3 : 2'd1;
				end else if (data_byte == CH_LF && blank_q == 2'd1) begin
					blank_d = 2'd2;
				end else begin
					blank_d = 2'd0;
				end
			end
			PH_SIZE: begin
				if (!closed_q && hx.ok && dcnt_q >= DCNT_W'(MAX_SIZE_DIGITS)) begin
					err_d   = ST_TOO_LONG;
					phase_d = PH_DONE;
				end else begin
					if (!closed_q && hx.ok) begin
						acc_d  = {acc_q[27:0], hx.val};
						dcnt_d = dcnt_q + DCNT_W'(1);
					end else begin
						closed_d = 1'b1;
					end
					if (data_byte == CH_LF && cr_q) begin
						if (acc_d == 32'd0) begin
							phase_d = PH_DONE;
						end else begin
							remain_d = acc_d;
							phase_d  = PH_DATA;
						end
					end else begin
						cr_d = (data_byte == CH_CR);
					end
				end
			end
			PH_DATA: begin
				remain_d = remain_q - 32'd1;
				if (remain_d == 32'd0) begin
					tskip_d = 2'd2;
					phase_d = PH_TRAILER;
				end
			end
			PH_TRAILER: begin
				if (tskip_q != 2'd0) begin
					tskip_d = tskip_q - 2'd1;
				end
				if (tskip_d == 2'd0) begin
					acc_d    = '0;
					dcnt_d   = '0;
					closed_d = 1'b0;
					cr_d     = 1'b0;
					phase_d  = PH_SIZE;
				end
			end
			default: begin
			end
		endcase

		// status is judged on the state left by this byte
		if (err_d == ST_TOO_LONG) begin
			st = ST_TOO_LONG;
		end else if (phase_d == PH_PASS || phase_d == PH_DONE) begin
			st = ST_OK;
		end else begin
			st = ST_TRUNC;
		end

		push.byte_v     = emit;
		push.byte_val   = data_byte;
		push.byte_kind  = (phase_q == PH_HEADER) ? KIND_HEADER : KIND_BODY;
		push.rep_v      = end_of_response;
		push.rep_status = st;
		push.rep_length = len_d;

		// final byte: start over for the next response
		if (end_of_response) begin
			phase_d  = PH_HEADER;
			blank_d  = '0;
			kw_d     = '0;
			seen_d   = 1'b0;
			acc_d    = '0;
			dcnt_d   = '0;
			closed_d = 1'b0;
			cr_d     = 1'b0;
			remain_d = '0;
			tskip_d  = '0;
			len_d    = '0;
			err_d    = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			blank_q  <= '0;
			kw_q     <= '0;
			seen_q   <= 1'b0;
			acc_q    <= '0;
			dcnt_q   <= '0;
			closed_q <= 1'b0;
			cr_q     <= 1'b0;
			remain_q <= '0;
			tskip_q  <= '0;
			len_q    <= '0;
			err_q    <= ST_OK;
		end else if (accept) begin
			phase_q  <= phase_d;
			blank_q  <= blank_d;
			kw_q     <= kw_d;
			seen_q   <= seen_d;
			acc_q    <= acc_d;
			dcnt_q   <= dcnt_d;
			closed_q <= closed_d;
			cr_q     <= cr_d;
			remain_q <= remain_d;
			tskip_q  <= tskip_d;
			len_q    <= len_d;
			err_q    <= err_d;
		end
	end

endmodule

FILE: rtl/hcbd_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_out_buf: two-slot result register
// Holds the byte result and the end report of one word; the byte goes out
// first.
// ----------------------------------------------------------------------------
module hcbd_out_buf import hcbd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  push_t       push,
	output logic        ready,
	hcbd_body_if.source body
);

	logic        byte_v_q;
	logic        rep_v_q;
	logic [7:0]  byte_val_q;
	kind_t       byte_kind_q;
	status_t     rep_status_q;
	logic [31:0] rep_length_q;
	logic        take;

	assign take  = body.valid && body.ready;
	assign ready = (!byte_v_q && !rep_v_q) || (body.ready && (byte_v_q ^ rep_v_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_v_q <= 1'b0;
			rep_v_q  <= 1'b0;
		end else if (accept) begin
			byte_v_q <= push.byte_v;
			rep_v_q  <= push.rep_v;
		end else if (take) begin
			if (byte_v_q) begin
				byte_v_q <= 1'b0;
			end else begin
				rep_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_val_q   <= push.byte_val;
			byte_kind_q  <= push.byte_kind;
			rep_status_q <= push.rep_status;
			rep_length_q <= push.rep_length;
		end
	end

	assign body.valid        = byte_v_q || rep_v_q;
	assign body.out_byte     = byte_v_q ? byte_val_q : 8'd0;
	assign body.item_kind    = byte_v_q ? byte_kind_q : KIND_REPORT;
	assign body.status       = byte_v_q ? ST_OK : rep_status_q;
	assign body.total_length = byte_v_q ? 32'd0 : rep_length_q;
	assign body.last_result  = !byte_v_q;

endmodule
